/* rtl/core/snfcs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snfcs_pkg
// shared types, opcodes and helpers for the spi nor flash command sequencer
// ----------------------------------------------------------------------------
package snfcs_pkg;

   // payload widths
   localparam int ACT_W  = 3;
   localparam int ADDR_W = 24;
   localparam int LEN_W  = 16;
   localparam int BYTE_W = 8;
   localparam int STAT_W = 2;

   // page size default, must be a power of two
   localparam int PAGE_BYTES_DEF = 256;

   // burst buffer depth; one input word gives at most five words
   localparam int MAX_RES = 6;
   localparam int CNT_W   = $clog2(MAX_RES + 1);

   // action codes
   localparam logic [ACT_W-1:0] ACT_READ_ID     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_READ        = 3'd1;
   localparam logic [ACT_W-1:0] ACT_WRITE       = 3'd2;
   localparam logic [ACT_W-1:0] ACT_SECTOR_ERASE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_BULK_ERASE  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_PAYLOAD     = 3'd5;
   localparam logic [ACT_W-1:0] ACT_REPLY       = 3'd6;

   // flash opcodes and fill byte
   localparam logic [BYTE_W-1:0] OP_PROGRAM      = 8'h02;
   localparam logic [BYTE_W-1:0] OP_WREN         = 8'h06;
   localparam logic [BYTE_W-1:0] OP_SECTOR_ERASE = 8'h20;
   localparam logic [BYTE_W-1:0] OP_BULK_ERASE   = 8'hC7;
   localparam logic [BYTE_W-1:0] OP_READ         = 8'h03;
   localparam logic [BYTE_W-1:0] OP_JEDEC_ID     = 8'h9F;
   localparam logic [BYTE_W-1:0] OP_RDSR         = 8'h05;
   localparam logic [BYTE_W-1:0] FILL_BYTE       = 8'hA5;
   localparam int                WIP_BIT         = 0;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_BUSY = 2'd1;
   localparam logic [STAT_W-1:0] ST_DONE = 2'd2;

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_ID    = 6'b000010,
      PH_READ  = 6'b000100,
      PH_WDATA = 6'b001000,
      PH_ACK   = 6'b010000,
      PH_POLL  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] mosi_byte;
      logic              send_valid;
      logic              frame_end;
      logic              expect_reply;
      logic              read_valid;
      logic [BYTE_W-1:0] read_data;
      logic              id_valid;
      logic [ADDR_W-1:0] id_value;
      logic [STAT_W-1:0] status;
      logic              last;
   } rsp_type;

   // byte to shift out
   function automatic rsp_type tx_word(logic [BYTE_W-1:0] b, logic fe, logic er);
      rsp_type w;
      w = '0;
      w.mosi_byte    = b;
      w.send_valid   = 1'b1;
      w.frame_end    = fe;
      w.expect_reply = er;
      return w;
   endfunction

   // status-only word
   function automatic rsp_type stat_word(logic [STAT_W-1:0] st);
      rsp_type w;
      w = '0;
      w.status = st;
      return w;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/snfcs_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snfcs_req_if
// command channel: valid/ready with action, address, length and data byte
// ----------------------------------------------------------------------------
interface snfcs_req_if;
   import snfcs_pkg::*;

   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [ADDR_W-1:0] address;
   logic [LEN_W-1:0]  length;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, action, address, length, data_byte, input ready);
   modport sink   (input valid, action, address, length, data_byte, output ready);
endinterface
`default_nettype wire

/* rtl/core/snfcs_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snfcs_rsp_if
// result channel: valid/ready with spi byte, read data, id and status
// ----------------------------------------------------------------------------
interface snfcs_rsp_if;
   import snfcs_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] mosi_byte;
   logic              send_valid;
   logic              frame_end;
   logic              expect_reply;
   logic              read_valid;
   logic [BYTE_W-1:0] read_data;
   logic              id_valid;
   logic [ADDR_W-1:0] id_value;
   logic [STAT_W-1:0] status;
   logic              last;

   modport source (output valid, mosi_byte, send_valid, frame_end, expect_reply,
                   read_valid, read_data, id_valid, id_value, status, last,
                   input ready);
   modport sink   (input valid, mosi_byte, send_valid, frame_end, expect_reply,
                   read_valid, read_data, id_valid, id_value, status, last,
                   output ready);
endinterface
`default_nettype wire

/* rtl/core/spi_nor_flash_command_sequencer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer
// host side sequencer for a 24-bit-address spi nor flash
// ----------------------------------------------------------------------------
// path: an accepted word sits in the input register, then its burst is loaded
// into the result buffer; throughput: one input word per cycle while the buffer
//   has room; a word giving k results (k up to 5) holds it until all k go, so the rsp side sets the pace
// reset: synchronous; phase returns to idle, buffers empty, ready high
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer #(
   parameter int PAGE_BYTES = snfcs_pkg::PAGE_BYTES_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   snfcs_req_if.sink   req_ch,
   snfcs_rsp_if.source rsp_ch
);
   import snfcs_pkg::*;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;

   // burst from the core
   rsp_type [MAX_RES-1:0] res_words;
   logic [CNT_W-1:0]      res_count;
   logic                  can_load;
   logic                  core_take;
   logic                  req_take;

   // the held word is consumed as soon as the result buffer has room
   assign core_take    = in_valid_ff && can_load;
   assign req_ch.ready = !in_valid_ff || can_load;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (core_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.action    <= req_ch.action;
         in_item_ff.address   <= req_ch.address;
         in_item_ff.length    <= req_ch.length;
         in_item_ff.data_byte <= req_ch.data_byte;
      end
   end

   // sequencer: state update and the full burst for one word
   snfcs_core #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (core_take),
      .item      (in_item_ff),
      .res_words (res_words),
      .res_count (res_count)
   );

   // words that give no result just update the state
   snfcs_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .load       (core_take && res_count != '0),
      .load_words (res_words),
      .load_count (res_count),
      .can_load   (can_load),
      .rsp_ch     (rsp_ch)
   );

endmodule
`default_nettype wire

/* rtl/core/snfcs_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snfcs_core
// sequencer state and the full word burst for one input word
// ----------------------------------------------------------------------------
module snfcs_core #(
   parameter int PAGE_BYTES = snfcs_pkg::PAGE_BYTES_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  take,
   input  wire snfcs_pkg::req_type                    item,
   output snfcs_pkg::rsp_type [snfcs_pkg::MAX_RES-1:0] res_words,
   output logic [snfcs_pkg::CNT_W-1:0]                res_count
);
   import snfcs_pkg::*;

   localparam int OFS_W = $clog2(PAGE_BYTES);
   localparam int PW    = OFS_W + 1;

   phase_type         phase_ff, phase_in;
   logic [ACT_W-1:0]  op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic [PW-1:0]     page_left_ff, page_left_in;
   logic [ADDR_W-1:0] id_shift_ff, id_shift_in;
   logic [1:0]        id_count_ff, id_count_in;

   // page start: from the command when idle, else from the running state
   logic              sp_cmd;
   logic [ADDR_W-1:0] sp_addr;
   logic [LEN_W-1:0]  sp_remain;
   logic [PW-1:0]     sp_room;
   logic [PW-1:0]     sp_first;

   rsp_type [MAX_RES-1:0] words;
   logic [CNT_W-1:0]      n;
   logic                  wend;

   assign sp_cmd    = (phase_ff == PH_IDLE);
   assign sp_addr   = sp_cmd ? item.address : addr_ff;
   assign sp_remain = sp_cmd ? item.length : remain_ff;
   assign sp_room   = PW'(PAGE_BYTES) - PW'(sp_addr[OFS_W-1:0]);
   assign sp_first  = (LEN_W'(sp_room) > sp_remain) ? PW'(sp_remain) : sp_room;
   assign wend      = (page_left_ff == PW'(1));

   always_comb begin
      words        = '0;
      n            = '0;
      phase_in     = phase_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      remain_in    = remain_ff;
      page_left_in = page_left_ff;
      id_shift_in  = id_shift_ff;
      id_count_in  = id_count_ff;

      if (item.action inside {[ACT_READ_ID:ACT_BULK_ERASE]}) begin
         if (phase_ff != PH_IDLE) begin
            words[0] = stat_word(ST_BUSY);
            n        = CNT_W'(1);
         end else begin
            op_in     = item.action;
            addr_in   = item.address;
            remain_in = item.length;
            case (item.action)
               ACT_READ_ID: begin
                  id_shift_in = '0;
                  id_count_in = '0;
                  words[0] = tx_word(OP_JEDEC_ID, 1'b0, 1'b0);
                  words[1] = tx_word(FILL_BYTE, 1'b0, 1'b1);
                  words[2] = tx_word(FILL_BYTE, 1'b0, 1'b1);
                  words[3] = tx_word(FILL_BYTE, 1'b1, 1'b1);
                  n        = CNT_W'(4);
                  phase_in = PH_ID;
               end
               ACT_READ: begin
                  words[0] = tx_word(OP_READ, 1'b0, 1'b0);
                  words[1] = tx_word(item.address[23:16], 1'b0, 1'b0);
                  words[2] = tx_word(item.address[15:8], 1'b0, 1'b0);
                  n        = CNT_W'(5);
                  if (item.length == '0) begin
                     // frame ends on the address, done right away
                     words[3] = tx_word(item.address[7:0], 1'b1, 1'b0);
                     words[4] = stat_word(ST_DONE);
                     phase_in = PH_IDLE;
                  end else begin
                     words[3]  = tx_word(item.address[7:0], 1'b0, 1'b0);
                     words[4]  = tx_word(FILL_BYTE, item.length == LEN_W'(1), 1'b1);
                     remain_in = item.length - LEN_W'(1);
                     phase_in  = PH_READ;
                  end
               end
               ACT_WRITE: begin
                  if (item.length == '0) begin
                     words[0] = stat_word(ST_DONE);
                     n        = CNT_W'(1);
                     phase_in = PH_IDLE;
                  end else begin
                     page_left_in = sp_first;
                     words[0] = tx_word(OP_WREN, 1'b1, 1'b0);
                     words[1] = tx_word(OP_PROGRAM, 1'b0, 1'b0);
                     words[2] = tx_word(sp_addr[23:16], 1'b0, 1'b0);
                     words[3] = tx_word(sp_addr[15:8], 1'b0, 1'b0);
                     words[4] = tx_word(sp_addr[7:0], 1'b0, 1'b0);
                     n        = CNT_W'(5);
                     phase_in = PH_WDATA;
                  end
               end
               ACT_SECTOR_ERASE: begin
                  words[0] = tx_word(OP_WREN, 1'b1, 1'b0);
                  words[1] = tx_word(OP_SECTOR_ERASE, 1'b0, 1'b0);
                  words[2] = tx_word(item.address[23:16], 1'b0, 1'b0);
                  words[3] = tx_word(item.address[15:8], 1'b0, 1'b0);
                  words[4] = tx_word(item.address[7:0], 1'b1, 1'b1);
                  n        = CNT_W'(5);
                  phase_in = PH_ACK;
               end
               default: begin
                  words[0] = tx_word(OP_WREN, 1'b1, 1'b0);
                  words[1] = tx_word(OP_BULK_ERASE, 1'b1, 1'b1);
                  n        = CNT_W'(2);
                  phase_in = PH_ACK;
               end
            endcase
         end
      end else if (item.action == ACT_PAYLOAD) begin
         if (phase_ff == PH_WDATA && page_left_ff != '0) begin
            page_left_in = page_left_ff - PW'(1);
            if (remain_ff != '0) begin
               remain_in = remain_ff - LEN_W'(1);
            end
            addr_in  = addr_ff + ADDR_W'(1);
            words[0] = tx_word(item.data_byte, wend, wend);
            n        = CNT_W'(1);
            if (wend) begin
               phase_in = PH_ACK;
            end
         end
      end else if (item.action == ACT_REPLY) begin
         case (phase_ff)
            PH_ID: begin
               id_shift_in = {id_shift_ff[15:0], item.data_byte};
               if (id_count_ff == 2'd2) begin
                  words[0]          = stat_word(ST_DONE);
                  words[0].id_valid = 1'b1;
                  words[0].id_value = {id_shift_ff[15:0], item.data_byte};
                  n                 = CNT_W'(1);
                  id_count_in       = '0;
                  phase_in          = PH_IDLE;
               end else begin
                  id_count_in = id_count_ff + 2'd1;
               end
            end
            PH_READ: begin
               addr_in = addr_ff + ADDR_W'(1);
               n       = CNT_W'(1);
               if (remain_ff != '0) begin
                  words[0] = tx_word(FILL_BYTE, remain_ff == LEN_W'(1), 1'b1);
                  remain_in = remain_ff - LEN_W'(1);
               end else begin
                  words[0] = stat_word(ST_DONE);
                  phase_in = PH_IDLE;
               end
               words[0].read_valid = 1'b1;
               words[0].read_data  = item.data_byte;
            end
            PH_ACK: begin
               words[0] = tx_word(OP_RDSR, 1'b0, 1'b0);
               words[1] = tx_word(FILL_BYTE, 1'b1, 1'b1);
               n        = CNT_W'(2);
               phase_in = PH_POLL;
            end
            PH_POLL: begin
               if (item.data_byte[WIP_BIT]) begin
                  words[0] = tx_word(OP_RDSR, 1'b0, 1'b0);
                  words[1] = tx_word(FILL_BYTE, 1'b1, 1'b1);
                  n        = CNT_W'(2);
               end else if (op_ff == ACT_WRITE && remain_ff != '0) begin
                  // next page of the write
                  page_left_in = sp_first;
                  words[0] = tx_word(OP_WREN, 1'b1, 1'b0);
                  words[1] = tx_word(OP_PROGRAM, 1'b0, 1'b0);
                  words[2] = tx_word(sp_addr[23:16], 1'b0, 1'b0);
                  words[3] = tx_word(sp_addr[15:8], 1'b0, 1'b0);
                  words[4] = tx_word(sp_addr[7:0], 1'b0, 1'b0);
                  n        = CNT_W'(5);
                  phase_in = PH_WDATA;
               end else begin
                  words[0] = stat_word(ST_DONE);
                  n        = CNT_W'(1);
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               n = '0;
            end
         endcase
      end

      // mark the final word of the burst
      for (int i = 0; i < MAX_RES; i++) begin
         words[i].last = (CNT_W'(i + 1) == n);
      end
   end

   assign res_words = words;
   assign res_count = n;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         op_ff        <= '0;
         addr_ff      <= '0;
         remain_ff    <= '0;
         page_left_ff <= '0;
         id_shift_ff  <= '0;
         id_count_ff  <= '0;
      end else if (take) begin
         phase_ff     <= phase_in;
         op_ff        <= op_in;
         addr_ff      <= addr_in;
         remain_ff    <= remain_in;
         page_left_ff <= page_left_in;
         id_shift_ff  <= id_shift_in;
         id_count_ff  <= id_count_in;
      end
   end

   // a rejected command leaves the sequence untouched
   a_busy_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (take && item.action <= ACT_BULK_ERASE && phase_ff != PH_IDLE) |=>
      ($stable(phase_ff) && $stable(addr_ff) && $stable(remain_ff)))
      else $error("busy command changed sequencer state");

   // a page in its data phase always has bytes still to send
   a_wdata_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WDATA) |-> (page_left_ff != '0))
      else $error("data phase with empty page");

endmodule
`default_nettype wire

/* rtl/core/snfcs_burst.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snfcs_burst
// result buffer, loaded with a whole burst, drains one word per cycle on ready
// ----------------------------------------------------------------------------
module snfcs_burst (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  load,
   input  wire snfcs_pkg::rsp_type [snfcs_pkg::MAX_RES-1:0] load_words,
   input  wire logic [snfcs_pkg::CNT_W-1:0]           load_count,
   output logic                                       can_load,
   snfcs_rsp_if.source                                rsp_ch
);
   import snfcs_pkg::*;

   rsp_type [MAX_RES-1:0] words_ff, words_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  drain;

   assign drain    = rsp_ch.valid && rsp_ch.ready;
   // free now, or the final word leaves this cycle
   assign can_load = (count_ff == '0) || (count_ff == CNT_W'(1) && rsp_ch.ready);

   always_comb begin
      words_in = words_ff;
      count_in = count_ff;
      if (load) begin
         words_in = load_words;
         count_in = load_count;
      end else if (drain) begin
         for (int i = 0; i < MAX_RES - 1; i++) begin
            words_in[i] = words_ff[i + 1];
         end
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

   assign rsp_ch.valid        = (count_ff != '0);
   assign rsp_ch.mosi_byte    = words_ff[0].mosi_byte;
   assign rsp_ch.send_valid   = words_ff[0].send_valid;
   assign rsp_ch.frame_end    = words_ff[0].frame_end;
   assign rsp_ch.expect_reply = words_ff[0].expect_reply;
   assign rsp_ch.read_valid   = words_ff[0].read_valid;
   assign rsp_ch.read_data    = words_ff[0].read_data;
   assign rsp_ch.id_valid     = words_ff[0].id_valid;
   assign rsp_ch.id_value     = words_ff[0].id_value;
   assign rsp_ch.status       = words_ff[0].status;
   assign rsp_ch.last         = words_ff[0].last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RES))
      else $error("burst count out of range");

   // a new burst never overwrites words still waiting
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (count_ff == '0 || (count_ff == CNT_W'(1) && drain)))
      else $error("burst loaded over pending words");

endmodule
`default_nettype wire

/* dv/tb_spi_nor_flash_command_sequencer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spi_nor_flash_command_sequencer
// self-checking bench for the spi nor flash command sequencer: every accepted
// command, payload or reply word runs through a behavioral copy of the
// sequencer, and every result word is compared field by field, in order,
// with what that copy predicts
// ----------------------------------------------------------------------------
module tb_spi_nor_flash_command_sequencer;
   import snfcs_pkg::*;

   localparam int PAGE = PAGE_BYTES_DEF;
   localparam int PAGE_W = $clog2(PAGE) + 1;
   localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE - 1);
   // action 7 has no meaning, the block drops it
   localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
   // no word moving for this long means the block is stuck
   localparam int QUIET_LIMIT = 3000;
   // cycles the result side is held off in the backpressure test
   localparam int LONG_HOLD = 150;
   // settle time after the last result
   localparam int TAIL_CYCLES = 20;

   logic clock;
   logic reset = 1'b1;

   snfcs_req_if req_ch ();
   snfcs_rsp_if rsp_ch ();

   spi_nor_flash_command_sequencer #(
      .PAGE_BYTES(PAGE)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // behavioral copy of the sequencer state
   // ---------------------------------------------------------------------------
   phase_type             flash_phase = PH_IDLE;
   logic [ACT_W-1:0]      flash_op = '0;
   logic [ADDR_W-1:0]     flash_addr = '0;
   logic [LEN_W-1:0]      flash_left = '0;
   logic [PAGE_W-1:0]     flash_page_left = '0;
   logic [ADDR_W-1:0]     id_shift = '0;
   logic [1:0]            id_count = '0;

   // words produced by the word being modeled, then the ordered store of all
   // result words still owed by the block
   rsp_type step_words[$];
   rsp_type words_due[$];

   // idling knobs and the long hold request picked up by the result sink
   int unsigned send_idle_pct = 38;
   int unsigned recv_stall_pct = 56;
   int unsigned hold_request = 0;

   // bookkeeping for the summary and the verdict
   int mismatches = 0;
   int words_checked = 0;
   int items_done = 0;
   int busy_rejects = 0;
   int pages_programmed = 0;
   int wip_polls = 0;
   int ops_started[0:4] = '{default: 0};

   function automatic void stage_word(input logic [BYTE_W-1:0] mosi, input logic send,
                                      input logic fe, input logic er, input logic rv,
                                      input logic [BYTE_W-1:0] rd, input logic iv,
                                      input logic [ADDR_W-1:0] idv,
                                      input logic [STAT_W-1:0] st);
      rsp_type w;
      w              = '0;
      w.mosi_byte    = mosi;
      w.send_valid   = send;
      w.frame_end    = fe;
      w.expect_reply = er;
      w.read_valid   = rv;
      w.read_data    = rd;
      w.id_valid     = iv;
      w.id_value     = idv;
      w.status       = st;
      step_words.push_back(w);
   endfunction

   // one spi byte with no read data or status
   function automatic void stage_spi(input logic [BYTE_W-1:0] b, input logic fe,
                                     input logic er);
      stage_word(b, 1'b1, fe, er, 1'b0, '0, 1'b0, '0, ST_OK);
   endfunction

   // three address bytes, msb first; only the low byte may close the frame
   function automatic void stage_address(input logic [ADDR_W-1:0] a, input logic fe,
                                         input logic er);
      stage_spi(a[23:16], 1'b0, 1'b0);
      stage_spi(a[15:8], 1'b0, 1'b0);
      stage_spi(a[7:0], fe, er);
   endfunction

   function automatic void stage_done();
      stage_word('0, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0, ST_DONE);
      flash_phase = PH_IDLE;
   endfunction

   // write enable frame, then program opcode and address; the page holds
   // whatever fits before the next page boundary
   function automatic void begin_page();
      int room;
      room = PAGE - int'(flash_addr % PAGE);
      flash_page_left = PAGE_W'((room > int'(flash_left)) ? int'(flash_left) : room);
      stage_spi(OP_WREN, 1'b1, 1'b0);
      stage_spi(OP_PROGRAM, 1'b0, 1'b0);
      stage_address(flash_addr, 1'b0, 1'b0);
      flash_phase = PH_WDATA;
      pages_programmed++;
   endfunction

   // rdsr frame, the fill byte brings back the status register
   function automatic void begin_poll();
      stage_spi(OP_RDSR, 1'b0, 1'b0);
      stage_spi(FILL_BYTE, 1'b1, 1'b1);
      flash_phase = PH_POLL;
   endfunction

   function automatic void start_command(input req_type w);
      flash_op   = w.action;
      flash_addr = w.address;
      flash_left = w.length;
      ops_started[w.action]++;
      case (w.action)
         ACT_READ_ID: begin
            id_shift = '0;
            id_count = '0;
            stage_spi(OP_JEDEC_ID, 1'b0, 1'b0);
            stage_spi(FILL_BYTE, 1'b0, 1'b1);
            stage_spi(FILL_BYTE, 1'b0, 1'b1);
            stage_spi(FILL_BYTE, 1'b1, 1'b1);
            flash_phase = PH_ID;
         end
         ACT_READ: begin
            stage_spi(OP_READ, 1'b0, 1'b0);
            if (w.length == 0) begin
               // nothing to fetch: the frame closes on the address
               stage_address(w.address, 1'b1, 1'b0);
               stage_done();
            end else begin
               stage_address(w.address, 1'b0, 1'b0);
               stage_spi(FILL_BYTE, w.length == 1, 1'b1);
               flash_left  = w.length - 1'b1;
               flash_phase = PH_READ;
            end
         end
         ACT_WRITE: begin
            if (w.length == 0) stage_done();
            else begin_page();
         end
         ACT_SECTOR_ERASE: begin
            stage_spi(OP_WREN, 1'b1, 1'b0);
            stage_spi(OP_SECTOR_ERASE, 1'b0, 1'b0);
            stage_address(w.address, 1'b1, 1'b1);
            flash_phase = PH_ACK;
         end
         default: begin
            stage_spi(OP_WREN, 1'b1, 1'b0);
            stage_spi(OP_BULK_ERASE, 1'b1, 1'b1);
            flash_phase = PH_ACK;
         end
      endcase
   endfunction

   function automatic void take_reply(input logic [BYTE_W-1:0] b);
      case (flash_phase)
         PH_ID: begin
            id_shift = {id_shift[15:0], b};
            id_count = id_count + 1'b1;
            if (id_count == 2'd3) begin
               stage_word('0, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1, id_shift, ST_DONE);
               id_count = '0;
               flash_phase = PH_IDLE;
            end
         end
         PH_READ: begin
            flash_addr = flash_addr + 1'b1;
            if (flash_left != 0) begin
               // read byte rides along with the next fill byte
               stage_word(FILL_BYTE, 1'b1, flash_left == 1, 1'b1, 1'b1, b, 1'b0, '0,
                          ST_OK);
               flash_left = flash_left - 1'b1;
            end else begin
               stage_word('0, 1'b0, 1'b0, 1'b0, 1'b1, b, 1'b0, '0, ST_DONE);
               flash_phase = PH_IDLE;
            end
         end
         PH_ACK: begin
            begin_poll();
         end
         PH_POLL: begin
            if (b[WIP_BIT]) begin
               wip_polls++;
               begin_poll();
            end else if (flash_op == ACT_WRITE && flash_left != 0) begin
               begin_page();
            end else begin
               stage_done();
            end
         end
         default: ;
      endcase
   endfunction

   // models one accepted word, queues its results with last on the final one,
   // and tells whether the word did anything
   function automatic bit model_flash_word(input req_type w);
      bit effect;
      effect = 1'b0;
      step_words.delete();
      if (w.action <= ACT_BULK_ERASE) begin
         effect = 1'b1;
         if (flash_phase != PH_IDLE) begin
            stage_word('0, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0, ST_BUSY);
            busy_rejects++;
         end else begin
            start_command(w);
         end
      end else if (w.action == ACT_PAYLOAD) begin
         if (flash_phase == PH_WDATA && flash_page_left != 0) begin
            effect = 1'b1;
            flash_page_left = flash_page_left - 1'b1;
            if (flash_left != 0) flash_left = flash_left - 1'b1;
            flash_addr = flash_addr + 1'b1;
            stage_spi(w.data_byte, flash_page_left == 0, flash_page_left == 0);
            if (flash_page_left == 0) flash_phase = PH_ACK;
         end
      end else if (w.action == ACT_REPLY) begin
         effect = (flash_phase != PH_IDLE && flash_phase != PH_WDATA);
         take_reply(w.data_byte);
      end
      foreach (step_words[i]) begin
         if (i == step_words.size() - 1) step_words[i].last = 1'b1;
         words_due.push_back(step_words[i]);
      end
      return effect;
   endfunction

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------
   // offers one word and returns at the edge that takes it; valid stays high so
   // that a following word can go out back to back
   task automatic send_word(input logic [ACT_W-1:0] act, input logic [ADDR_W-1:0] addr,
                            input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] b);
      req_type w;
      w.action    = act;
      w.address   = addr;
      w.length    = len;
      w.data_byte = b;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.address   <= addr;
      req_ch.length    <= len;
      req_ch.data_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (model_flash_word(w)) items_done++;
   endtask

   // sender pause: nothing is offered until every owed result has arrived
   task automatic wait_all_delivered();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (words_due.size() != 0) @(posedge clock);
   endtask

   // drives whatever the current phase waits for, sprinkled with stray words:
   // commands while busy, payload or replies nobody asked for, action 7
   task automatic finish_operation(input int unsigned noise_pct);
      logic [BYTE_W-1:0] b;
      while (flash_phase != PH_IDLE) begin
         b = BYTE_W'($urandom);
         if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(2))
               0: send_word(ACT_W'($urandom_range(int'(ACT_BULK_ERASE))),
                            ADDR_W'($urandom), LEN_W'($urandom), b);
               1: send_word((flash_phase == PH_WDATA) ? ACT_REPLY : ACT_PAYLOAD,
                            ADDR_W'($urandom), LEN_W'($urandom), b);
               default: send_word(ACT_UNUSED, ADDR_W'($urandom), LEN_W'($urandom), b);
            endcase
         end else begin
            case (flash_phase)
               PH_WDATA: send_word(ACT_PAYLOAD, ADDR_W'($urandom), LEN_W'($urandom), b);
               PH_POLL: begin
                  // flash stays busy now and then
                  b[WIP_BIT] = ($urandom_range(99) < 30);
                  send_word(ACT_REPLY, ADDR_W'($urandom), LEN_W'($urandom), b);
               end
               default: send_word(ACT_REPLY, ADDR_W'($urandom), LEN_W'($urandom), b);
            endcase
         end
      end
   endtask

   // one whole random operation; lengths stay short, addresses often sit just
   // below a page boundary so writes split
   task automatic run_random_operation();
      int unsigned pick;
      logic [ADDR_W-1:0] a;
      logic [LEN_W-1:0] n;
      pick = $urandom_range(99);
      a = ADDR_W'($urandom);
      n = LEN_W'($urandom);
      if ($urandom_range(19) == 0)
         send_word($urandom_range(1) ? ACT_PAYLOAD : ACT_REPLY, a, n, BYTE_W'($urandom));
      if (pick < 15) begin
         send_word(ACT_READ_ID, a, n, BYTE_W'($urandom));
      end else if (pick < 40) begin
         n = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(24)) :
                                        LEN_W'($urandom_range(6));
         send_word(ACT_READ, a, n, BYTE_W'($urandom));
      end else if (pick < 75) begin
         if ($urandom_range(1))
            a = (a & ~PAGE_MASK) | (PAGE_MASK - ADDR_W'($urandom_range(3)));
         case ($urandom_range(11))
            0:       n = '0;
            1:       n = LEN_W'($urandom_range(24, 7));
            default: n = LEN_W'($urandom_range(6, 1));
         endcase
         send_word(ACT_WRITE, a, n, BYTE_W'($urandom));
      end else if (pick < 88) begin
         send_word(ACT_SECTOR_ERASE, a, n, BYTE_W'($urandom));
      end else begin
         send_word(ACT_BULK_ERASE, a, n, BYTE_W'($urandom));
      end
      finish_operation(10);
   endtask

   // ---------------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------------
   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      words_checked++;
      if (words_due.size() == 0) begin
         mismatches++;
         $display("%0t: result word with none expected, expected none, actual 0x%0h",
                  $time, got);
      end else begin
         want = words_due.pop_front();
         if (got.mosi_byte !== want.mosi_byte)
            report_field("mosi_byte", 32'(want.mosi_byte), 32'(got.mosi_byte));
         if (got.send_valid !== want.send_valid)
            report_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
         if (got.frame_end !== want.frame_end)
            report_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
         if (got.expect_reply !== want.expect_reply)
            report_field("expect_reply", 32'(want.expect_reply), 32'(got.expect_reply));
         if (got.read_valid !== want.read_valid)
            report_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
         if (got.read_data !== want.read_data)
            report_field("read_data", 32'(want.read_data), 32'(got.read_data));
         if (got.id_valid !== want.id_valid)
            report_field("id_valid", 32'(want.id_valid), 32'(got.id_valid));
         if (got.id_value !== want.id_value)
            report_field("id_value", 32'(want.id_value), 32'(got.id_value));
         if (got.status !== want.status)
            report_field("status", 32'(want.status), 32'(got.status));
         if (got.last !== want.last)
            report_field("last", 32'(want.last), 32'(got.last));
      end
   endtask

   // takes result words and drives ready: random stalls, or a long hold when a
   // test asks for one, counted here
   initial begin : result_sink
      rsp_type got;
      int unsigned hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.mosi_byte    = rsp_ch.mosi_byte;
            got.send_valid   = rsp_ch.send_valid;
            got.frame_end    = rsp_ch.frame_end;
            got.expect_reply = rsp_ch.expect_reply;
            got.read_valid   = rsp_ch.read_valid;
            got.read_data    = rsp_ch.read_data;
            got.id_valid     = rsp_ch.id_valid;
            got.id_value     = rsp_ch.id_value;
            got.status       = rsp_ch.status;
            got.last         = rsp_ch.last;
            check_result(got);
         end
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // ends the run if no word moves on either side for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (reset) @(posedge clock);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no word moved for %0d cycles, %0d result words still owed",
               $time, QUIET_LIMIT, words_due.size());
      $display("tb_spi_nor_flash_command_sequencer: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------
   // jedec id with all-zero and all-one id bytes
   task automatic test_read_id();
      send_word(ACT_READ_ID, 24'hFFFFFF, 16'hFFFF, 8'hFF);
      send_word(ACT_REPLY, 24'h000000, 16'h0000, 8'h00);
      send_word(ACT_REPLY, 24'hFFFFFF, 16'hFFFF, 8'hFF);
      send_word(ACT_REPLY, 24'h000000, 16'h0000, 8'h5A);
      wait_all_delivered();
   endtask

   // zero length read closes on the address; one byte read at the top of the
   // address space
   task automatic test_read();
      send_word(ACT_READ, 24'h000000, 16'h0000, 8'h00);
      send_word(ACT_READ, 24'hFFFFFF, 16'h0001, 8'h00);
      send_word(ACT_REPLY, 24'h000000, 16'h0000, 8'hFF);
      wait_all_delivered();
   endtask

   // empty write, then a two byte write that splits at the page edge and wraps
   // the address to zero, with one busy poll in between
   task automatic test_write();
      send_word(ACT_WRITE, 24'h123456, 16'h0000, 8'h00);
      send_word(ACT_WRITE, 24'hFFFFFF, 16'h0002, 8'h00);
      send_word(ACT_PAYLOAD, 24'h000000, 16'h0000, 8'hFF);
      send_word(ACT_REPLY, 24'h000000, 16'h0000, 8'h00);
      send_word(ACT_REPLY, 24'h000000, 16'h0000, 8'h01);
      send_word(ACT_REPLY, 24'h000000, 16'h0000, 8'hFE);
      send_word(ACT_PAYLOAD, 24'hFFFFFF, 16'hFFFF, 8'h00);
      send_word(ACT_REPLY, 24'h000000, 16'h0000, 8'hFF);
      send_word(ACT_REPLY, 24'h000000, 16'h0000, 8'h00);
      wait_all_delivered();
   endtask

   // sector erase with a busy poll, bulk erase with a command refused mid-way
   task automatic test_erase();
      send_word(ACT_SECTOR_ERASE, 24'h000000, 16'hFFFF, 8'h00);
      send_word(ACT_REPLY, 24'h000000, 16'h0000, 8'h00);
      send_word(ACT_REPLY, 24'h000000, 16'h0000, 8'hFF);
      send_word(ACT_REPLY, 24'h000000, 16'h0000, 8'h00);
      send_word(ACT_BULK_ERASE, 24'h000000, 16'h0000, 8'h00);
      send_word(ACT_READ, 24'hFFFFFF, 16'hFFFF, 8'hFF);
      send_word(ACT_REPLY, 24'h000000, 16'h0000, 8'h00);
      send_word(ACT_REPLY, 24'h000000, 16'h0000, 8'h00);
      wait_all_delivered();
   endtask

   // stray payload, stray reply and action 7 while idle: all dropped
   task automatic test_stray_words();
      send_word(ACT_PAYLOAD, 24'hFFFFFF, 16'hFFFF, 8'hFF);
      send_word(ACT_REPLY, 24'hFFFFFF, 16'hFFFF, 8'h01);
      send_word(ACT_UNUSED, 24'hFFFFFF, 16'hFFFF, 8'hFF);
      wait_all_delivered();
   endtask

   task automatic test_random(input int unsigned target);
      int start;
      start = items_done;
      while (items_done - start < target) run_random_operation();
      wait_all_delivered();
   endtask

   // result side held off while words keep coming, so the block backs up and
   // drops ready on the request side
   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_request  = LONG_HOLD;
      send_word(ACT_READ, ADDR_W'($urandom), 16'd12, BYTE_W'($urandom));
      finish_operation(0);
      send_word(ACT_BULK_ERASE, ADDR_W'($urandom), LEN_W'($urandom), BYTE_W'($urandom));
      finish_operation(0);
      wait_all_delivered();
   endtask

   initial begin
      req_ch.valid     <= 1'b0;
      req_ch.action    <= ACT_READ_ID;
      req_ch.address   <= '0;
      req_ch.length    <= '0;
      req_ch.data_byte <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed cases with the sender idling 38% and the receiver 56%
      test_read_id();
      test_read();
      test_write();
      test_erase();
      test_stray_words();

      test_random(85);
      send_idle_pct  = 56;
      recv_stall_pct = 38;
      test_random(85);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random(85);
      test_backpressure();

      // let any late or surplus word show up
      recv_stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d active words and %0d result words: %0d id, %0d read, %0d write,",
               items_done, words_checked, ops_started[ACT_READ_ID], ops_started[ACT_READ],
               ops_started[ACT_WRITE]);
      $display("%0d sector and %0d bulk erases, %0d pages, %0d busy polls, %0d refusals",
               ops_started[ACT_SECTOR_ERASE], ops_started[ACT_BULK_ERASE],
               pages_programmed, wip_polls, busy_rejects);
      if (mismatches == 0) $display("tb_spi_nor_flash_command_sequencer: PASS");
      else $display("tb_spi_nor_flash_command_sequencer: FAIL");
      $finish;
   end

endmodule
